[sv/qrv_pkg.sv]
// Package for the quaternion vector rotation block.
// Holds the datapath widths, the register index codes and reset values.
// No dependencies.
`default_nettype none

package qrv_pkg;

  localparam int unsigned QW    = 16;   // quaternion component and point width
  localparam int unsigned OW    = 17;   // rotated coordinate width
  localparam int unsigned SHIFT = 30;   // Q.30 to integer

  typedef logic signed [QW-1:0] qcomp_t;   // Q1.15 component or integer point coordinate
  typedef logic signed [31:0]   prod1_t;   // q * p product
  typedef logic signed [32:0]   tsum_t;    // component of t = q * (0, p)
  typedef logic signed [48:0]   prod2_t;   // t * q product
  typedef logic signed [50:0]   acc_t;     // Q.30 sum with rounding offset
  typedef logic signed [20:0]   rnd_t;     // rounded integer before clamp
  typedef logic signed [OW-1:0] coord_t;   // saturated output coordinate

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_idx_t;

  localparam qcomp_t QUAT_W_RST = 16'sd32767;
  localparam qcomp_t QUAT_V_RST = 16'sd0;

  localparam acc_t   ROUND_HALF = acc_t'(64'sd1 <<< (SHIFT - 1));
  localparam rnd_t   OUT_MAX    = rnd_t'(65535);
  localparam rnd_t   OUT_MIN    = rnd_t'(-65536);

endpackage

`default_nettype wire

[sv/quaternion_rotate_vector.sv]
// Top level: rotates streamed 3-D points by r = q * (0, p) * conj(q).
// Depends on qrv_pkg for widths, register codes and reset values.
// Five-stage pipeline with per-stage valid bits and a backpressure chain.
`default_nettype none

// A point's result passes through the stage 0 to stage 4 registers to the output,
// and the pipeline takes one point per clock while the output is drained.
// The stages are: twelve 16x16 products of q and p, the three-term sums of
// t = q*(0,p), twelve 33x16 products of t and q, the four-term Q.30 sums with
// the rounding offset, then shift, saturation and the output register.
// The quaternion is not normalized, so a non-unit q scales the point by |q|^2.
// Quaternion registers should only be written while no point is in flight.
// Rounding is half toward plus infinity; results clamp to -65536..65535 and
// the overflow flag in out_tuser is set if any coordinate clamped.

module quaternion_rotate_vector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // point_x[15:0], point_y[31:16], point_z[47:32]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // rotated_x[16:0], rotated_y[33:17],
                                       // rotated_z[50:34], zeros[55:51]
  output logic             out_tuser   // overflow
);

  localparam int unsigned NSTG = 5;

  // configuration registers
  qrv_pkg::qcomp_t qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= qrv_pkg::QUAT_W_RST;
      qx_r <= qrv_pkg::QUAT_V_RST;
      qy_r <= qrv_pkg::QUAT_V_RST;
      qz_r <= qrv_pkg::QUAT_V_RST;
    end else if (cfg_wr_en) begin
      case (qrv_pkg::reg_idx_t'(cfg_addr))
        qrv_pkg::REG_QUAT_W: qw_r <= qrv_pkg::qcomp_t'(cfg_wdata);
        qrv_pkg::REG_QUAT_X: qx_r <= qrv_pkg::qcomp_t'(cfg_wdata);
        qrv_pkg::REG_QUAT_Y: qy_r <= qrv_pkg::qcomp_t'(cfg_wdata);
        qrv_pkg::REG_QUAT_Z: qz_r <= qrv_pkg::qcomp_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // valid bits and backpressure chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: products of q and p
  qrv_pkg::qcomp_t px, py, pz;
  assign px = qrv_pkg::qcomp_t'(in_tdata[15:0]);
  assign py = qrv_pkg::qcomp_t'(in_tdata[31:16]);
  assign pz = qrv_pkg::qcomp_t'(in_tdata[47:32]);

  qrv_pkg::prod1_t xpx_r, ypy_r, zpz_r;          // for tw
  qrv_pkg::prod1_t wpx_r, ypz_r, zpy_r;          // for tx
  qrv_pkg::prod1_t wpy_r, zpx_r, xpz_r;          // for ty
  qrv_pkg::prod1_t wpz_r, xpy_r, ypx_r;          // for tz

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xpx_r <= qrv_pkg::prod1_t'(qx_r) * qrv_pkg::prod1_t'(px);
      ypy_r <= qrv_pkg::prod1_t'(qy_r) * qrv_pkg::prod1_t'(py);
      zpz_r <= qrv_pkg::prod1_t'(qz_r) * qrv_pkg::prod1_t'(pz);
      wpx_r <= qrv_pkg::prod1_t'(qw_r) * qrv_pkg::prod1_t'(px);
      ypz_r <= qrv_pkg::prod1_t'(qy_r) * qrv_pkg::prod1_t'(pz);
      zpy_r <= qrv_pkg::prod1_t'(qz_r) * qrv_pkg::prod1_t'(py);
      wpy_r <= qrv_pkg::prod1_t'(qw_r) * qrv_pkg::prod1_t'(py);
      zpx_r <= qrv_pkg::prod1_t'(qz_r) * qrv_pkg::prod1_t'(px);
      xpz_r <= qrv_pkg::prod1_t'(qx_r) * qrv_pkg::prod1_t'(pz);
      wpz_r <= qrv_pkg::prod1_t'(qw_r) * qrv_pkg::prod1_t'(pz);
      xpy_r <= qrv_pkg::prod1_t'(qx_r) * qrv_pkg::prod1_t'(py);
      ypx_r <= qrv_pkg::prod1_t'(qy_r) * qrv_pkg::prod1_t'(px);
    end
  end

  // stage 1: t = q * (0, p)
  qrv_pkg::tsum_t tw_r, tx_r, ty_r, tz_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      tw_r <= -(qrv_pkg::tsum_t'(xpx_r) + qrv_pkg::tsum_t'(ypy_r) + qrv_pkg::tsum_t'(zpz_r));
      tx_r <= qrv_pkg::tsum_t'(wpx_r) + qrv_pkg::tsum_t'(ypz_r) - qrv_pkg::tsum_t'(zpy_r);
      ty_r <= qrv_pkg::tsum_t'(wpy_r) + qrv_pkg::tsum_t'(zpx_r) - qrv_pkg::tsum_t'(xpz_r);
      tz_r <= qrv_pkg::tsum_t'(wpz_r) + qrv_pkg::tsum_t'(xpy_r) - qrv_pkg::tsum_t'(ypx_r);
    end
  end

  // stage 2: products of t and q
  qrv_pkg::prod2_t xw_r, wx_r, yz_r, zy_r;       // for rx
  qrv_pkg::prod2_t yw_r, wy_r, zx_r, xz_r;       // for ry
  qrv_pkg::prod2_t zw_r, wz_r, xy_r, yx_r;       // for rz

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      xw_r <= qrv_pkg::prod2_t'(tx_r) * qrv_pkg::prod2_t'(qw_r);
      wx_r <= qrv_pkg::prod2_t'(tw_r) * qrv_pkg::prod2_t'(qx_r);
      yz_r <= qrv_pkg::prod2_t'(ty_r) * qrv_pkg::prod2_t'(qz_r);
      zy_r <= qrv_pkg::prod2_t'(tz_r) * qrv_pkg::prod2_t'(qy_r);
      yw_r <= qrv_pkg::prod2_t'(ty_r) * qrv_pkg::prod2_t'(qw_r);
      wy_r <= qrv_pkg::prod2_t'(tw_r) * qrv_pkg::prod2_t'(qy_r);
      zx_r <= qrv_pkg::prod2_t'(tz_r) * qrv_pkg::prod2_t'(qx_r);
      xz_r <= qrv_pkg::prod2_t'(tx_r) * qrv_pkg::prod2_t'(qz_r);
      zw_r <= qrv_pkg::prod2_t'(tz_r) * qrv_pkg::prod2_t'(qw_r);
      wz_r <= qrv_pkg::prod2_t'(tw_r) * qrv_pkg::prod2_t'(qz_r);
      xy_r <= qrv_pkg::prod2_t'(tx_r) * qrv_pkg::prod2_t'(qy_r);
      yx_r <= qrv_pkg::prod2_t'(ty_r) * qrv_pkg::prod2_t'(qx_r);
    end
  end

  // stage 3: Q.30 vector part of t * conj(q), with the rounding offset
  qrv_pkg::acc_t rx_r, ry_r, rz_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rx_r <= qrv_pkg::acc_t'(xw_r) - qrv_pkg::acc_t'(wx_r) - qrv_pkg::acc_t'(yz_r)
              + qrv_pkg::acc_t'(zy_r) + qrv_pkg::ROUND_HALF;
      ry_r <= qrv_pkg::acc_t'(yw_r) - qrv_pkg::acc_t'(wy_r) - qrv_pkg::acc_t'(zx_r)
              + qrv_pkg::acc_t'(xz_r) + qrv_pkg::ROUND_HALF;
      rz_r <= qrv_pkg::acc_t'(zw_r) - qrv_pkg::acc_t'(wz_r) - qrv_pkg::acc_t'(xy_r)
              + qrv_pkg::acc_t'(yx_r) + qrv_pkg::ROUND_HALF;
    end
  end

  // stage 4: floor shift, saturation, output register
  qrv_pkg::rnd_t   sx, sy, sz;
  qrv_pkg::coord_t cx, cy, cz;
  logic            ox, oy, oz;

  // Dropping the low 30 bits of a two's complement value is a floor.
  assign sx = qrv_pkg::rnd_t'(rx_r[50:30]);
  assign sy = qrv_pkg::rnd_t'(ry_r[50:30]);
  assign sz = qrv_pkg::rnd_t'(rz_r[50:30]);

  always_comb begin
    ox = 1'b1;
    oy = 1'b1;
    oz = 1'b1;
    if (sx > qrv_pkg::OUT_MAX) cx = qrv_pkg::coord_t'(qrv_pkg::OUT_MAX);
    else if (sx < qrv_pkg::OUT_MIN) cx = qrv_pkg::coord_t'(qrv_pkg::OUT_MIN);
    else begin
      cx = qrv_pkg::coord_t'(sx);
      ox = 1'b0;
    end
    if (sy > qrv_pkg::OUT_MAX) cy = qrv_pkg::coord_t'(qrv_pkg::OUT_MAX);
    else if (sy < qrv_pkg::OUT_MIN) cy = qrv_pkg::coord_t'(qrv_pkg::OUT_MIN);
    else begin
      cy = qrv_pkg::coord_t'(sy);
      oy = 1'b0;
    end
    if (sz > qrv_pkg::OUT_MAX) cz = qrv_pkg::coord_t'(qrv_pkg::OUT_MAX);
    else if (sz < qrv_pkg::OUT_MIN) cz = qrv_pkg::coord_t'(qrv_pkg::OUT_MIN);
    else begin
      cz = qrv_pkg::coord_t'(sz);
      oz = 1'b0;
    end
  end

  qrv_pkg::coord_t ox_coord_r, oy_coord_r, oz_coord_r;
  logic            ovf_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ox_coord_r <= cx;
      oy_coord_r <= cy;
      oz_coord_r <= cz;
      ovf_r      <= ox || oy || oz;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {5'b0, oz_coord_r, oy_coord_r, ox_coord_r};
  assign out_tuser  = ovf_r;

  // assertions
  logic in_xfer, out_xfer;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !out_xfer |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("pipeline occupancy did not grow on an input transfer");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !in_xfer |=> $countones(vld_r) + 1 == $past($countones(vld_r)))
    else $error("pipeline occupancy did not shrink on an output transfer");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ox_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MAX) ||
      ox_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MIN) ||
      oy_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MAX) ||
      oy_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MIN) ||
      oz_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MAX) ||
      oz_coord_r == qrv_pkg::coord_t'(qrv_pkg::OUT_MIN))
    else $error("overflow flagged but no coordinate is at a limit");

  a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_tready)
    else $error("input stalled while the pipeline has a free stage");

endmodule

`default_nettype wire
